// ===== rtl/utf8_stream_decoder_classifier_unit_assert.svh =====
// Assertion macros shared by the UTF-8 decoder RTL.
`ifndef UTF8_STREAM_DECODER_CLASSIFIER_UNIT_ASSERT_SVH
`define UTF8_STREAM_DECODER_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define USDC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("usdc assertion failed");

// Next-cycle implication, disabled in reset.
`define USDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("usdc assertion failed");

`endif

// ===== rtl/usdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usdc_pkg
// Types and constants for the UTF-8 stream decoder / classifier.
// ----------------------------------------------------------------------------
package usdc_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] SPACE_TOKEN_RST = 21'd9601;

  // minimum value per sequence length (overlong check)
  localparam logic [CP_W-1:0] MIN_2B = 21'h000080;
  localparam logic [CP_W-1:0] MIN_3B = 21'h000800;
  localparam logic [CP_W-1:0] MIN_4B = 21'h010000;

  localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_LIMIT = 21'h110000;

  // open sequence length
  typedef enum logic [2:0] {
    SEQ_NONE = 3'd0,
    SEQ_2    = 3'd2,
    SEQ_3    = 3'd3,
    SEQ_4    = 3'd4
  } seq_len_t;

  typedef struct packed {
    logic            has_result;
    logic            have;
    logic [CP_W-1:0] cp;
    logic            invalid_seen;
    logic            stream_end;
    logic            seq_open;
  } dec_res_t;

  typedef struct packed {
    logic space;
    logic punct;
    logic cjk;
  } class_t;

endpackage

// ===== rtl/usdc_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usdc_decode
// UTF-8 sequence state and one-byte decode step with validity checks.
// ----------------------------------------------------------------------------
module usdc_decode (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [7:0]                data_byte,
  input  logic                      last_byte,
  output usdc_pkg::dec_res_t        res
);

  usdc_pkg::seq_len_t              len, len_next;
  logic [1:0]                      held, held_next;
  logic [usdc_pkg::CP_W-1:0]       pv, pv_next;
  logic                            sticky, sticky_next;

  logic                            have;
  logic [usdc_pkg::CP_W-1:0]       cp;
  logic                            consumed;
  logic                            sticky_flag;
  logic [1:0]                      held_inc;
  logic [usdc_pkg::CP_W-1:0]       pv_shift;
  logic [usdc_pkg::CP_W-1:0]       minv;
  logic                            scalar_ok;

  assign held_inc = held + 2'd1;
  assign pv_shift = {pv[usdc_pkg::CP_W-7:0], data_byte[5:0]};

  always_comb begin
    case (len)
      usdc_pkg::SEQ_2: minv = usdc_pkg::MIN_2B;
      usdc_pkg::SEQ_3: minv = usdc_pkg::MIN_3B;
      default:         minv = usdc_pkg::MIN_4B;
    endcase
  end

  assign scalar_ok = (pv_shift < usdc_pkg::SURR_LO) ||
                     ((pv_shift > usdc_pkg::SURR_HI) && (pv_shift < usdc_pkg::CP_LIMIT));

  always_comb begin
    len_next    = len;
    held_next   = held;
    pv_next     = pv;
    sticky_flag = sticky;
    have        = 1'b0;
    cp          = '0;
    consumed    = 1'b0;

    if (len != usdc_pkg::SEQ_NONE) begin
      if (data_byte[7:6] == 2'b10) begin
        consumed  = 1'b1;
        pv_next   = pv_shift;
        held_next = held_inc;
        // held count wraps to zero on the fourth byte
        if (({1'b0, held_inc} == len) || (held_inc == 2'd0)) begin
          if ((pv_shift >= minv) && scalar_ok) begin
            have = 1'b1;
            cp   = pv_shift;
          end else begin
            sticky_flag = 1'b1;
          end
          len_next  = usdc_pkg::SEQ_NONE;
          held_next = 2'd0;
          pv_next   = '0;
        end
      end else begin
        // broken sequence: drop held bytes, byte re-read as a lead
        sticky_flag = 1'b1;
        len_next    = usdc_pkg::SEQ_NONE;
        held_next   = 2'd0;
        pv_next     = '0;
      end
    end

    if (!consumed) begin
      if (data_byte[7] == 1'b0) begin
        have = 1'b1;
        cp   = {13'd0, data_byte};
      end else if (data_byte[7:5] == 3'b110) begin
        len_next  = usdc_pkg::SEQ_2;
        held_next = 2'd1;
        pv_next   = {16'd0, data_byte[4:0]};
      end else if (data_byte[7:4] == 4'b1110) begin
        len_next  = usdc_pkg::SEQ_3;
        held_next = 2'd1;
        pv_next   = {17'd0, data_byte[3:0]};
      end else if (data_byte[7:3] == 5'b11110) begin
        len_next  = usdc_pkg::SEQ_4;
        held_next = 2'd1;
        pv_next   = {18'd0, data_byte[2:0]};
      end else begin
        sticky_flag = 1'b1;
      end
    end

    // truncated at end of stream
    if (last_byte && (len_next != usdc_pkg::SEQ_NONE)) begin
      sticky_flag = 1'b1;
    end

    sticky_next = sticky_flag;
    if (last_byte) begin
      len_next    = usdc_pkg::SEQ_NONE;
      held_next   = 2'd0;
      pv_next     = '0;
      sticky_next = 1'b0;
    end
  end

  always_comb begin
    res.has_result   = have || last_byte;
    res.have         = have;
    res.cp           = cp;
    res.invalid_seen = sticky_flag;
    res.stream_end   = last_byte;
    res.seq_open     = (len != usdc_pkg::SEQ_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len    <= usdc_pkg::SEQ_NONE;
      held   <= 2'd0;
      pv     <= '0;
      sticky <= 1'b0;
    end else if (step) begin
      len    <= len_next;
      held   <= held_next;
      pv     <= pv_next;
      sticky <= sticky_next;
    end
  end

endmodule

// ===== rtl/usdc_class.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usdc_class
// Space / punctuation / CJK ideograph classification of one code point.
// ----------------------------------------------------------------------------
module usdc_class (
  input  logic [usdc_pkg::CP_W-1:0] cp,
  input  logic                      have,
  input  logic [usdc_pkg::CP_W-1:0] blank_cp,
  output usdc_pkg::class_t          cls
);

  logic ws_hit, is_punct, is_cjk;

  assign ws_hit = ((cp >= 21'd9) && (cp <= 21'd13)) || (cp == 21'd32) ||
                  (cp == blank_cp);

  assign is_punct = ((cp >= 21'd33) && (cp <= 21'd47)) ||
                    ((cp >= 21'd58) && (cp <= 21'd64)) ||
                    ((cp >= 21'd91) && (cp <= 21'd96)) ||
                    ((cp >= 21'd123) && (cp <= 21'd126)) ||
                    (cp == 21'd171) || (cp == 21'd183) || (cp == 21'd187) ||
                    ((cp >= 21'd8208) && (cp <= 21'd8250));

  assign is_cjk = ((cp >= 21'h03400) && (cp <= 21'h04DBF)) ||
                  ((cp >= 21'h04E00) && (cp <= 21'h09FFF)) ||
                  ((cp >= 21'h0F900) && (cp <= 21'h0FAFF)) ||
                  ((cp >= 21'h20000) && (cp <= 21'h2A6DF)) ||
                  ((cp >= 21'h2A700) && (cp <= 21'h2CEAF)) ||
                  ((cp >= 21'h2F800) && (cp <= 21'h2FA1F));

  always_comb begin
    cls.space = have && ws_hit;
    cls.punct = have && is_punct;
    cls.cjk   = have && is_cjk;
  end

endmodule

// ===== rtl/utf8_stream_decoder_classifier_unit.sv =====
`timescale 1ns / 1ps
// Input accept to result valid passes the input register, then the result register.
// Throughput: one byte word per cycle unless out_ready stalls; the decode step
//   and the classifier sit between the input register and the result register.
// Reset (rst, synchronous): no sequence open, sticky drop flag clear,
//   space token = 9601, both pipeline registers empty.
// ----------------------------------------------------------------------------
// utf8_stream_decoder_classifier_unit
// UTF-8 byte stream decoder with space / punctuation / CJK classification.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_classifier_unit_assert.svh"

module utf8_stream_decoder_classifier_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [20:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] char_code,
  output logic        code_valid,
  output logic        space_flag,
  output logic        punct_flag,
  output logic        cjk_flag,
  output logic        invalid_seen,
  output logic        stream_end
);

  logic [usdc_pkg::CP_W-1:0] blank_cp;

  logic                      inq_valid;
  logic [7:0]                inq_byte;
  logic                      inq_last;

  logic                      adv;
  usdc_pkg::dec_res_t        dres;
  usdc_pkg::class_t          cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_cp <= usdc_pkg::SPACE_TOKEN_RST;
    end else if (cfg_wr_en) begin
      blank_cp <= cfg_wr_data;
    end
  end

  // move the held word through decode when the result slot can take it
  assign adv      = inq_valid && (!dres.has_result || !out_valid || out_ready);
  assign in_ready = !inq_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      inq_valid <= 1'b1;
    end else if (adv) begin
      inq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_byte <= data_byte;
      inq_last <= last_byte;
    end
  end

  usdc_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (adv),
    .data_byte (inq_byte),
    .last_byte (inq_last),
    .res       (dres)
  );

  usdc_class u_class (
    .cp       (dres.cp),
    .have     (dres.have),
    .blank_cp (blank_cp),
    .cls      (cls)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && dres.has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && dres.has_result) begin
      char_code    <= dres.cp;
      code_valid   <= dres.have;
      space_flag   <= cls.space;
      punct_flag   <= cls.punct;
      cjk_flag     <= cls.cjk;
      invalid_seen <= dres.invalid_seen;
      stream_end   <= dres.stream_end;
    end
  end

  `USDC_ASSERT_NOW(a_empty_result_zero, clk, rst, out_valid && !code_valid,
    (char_code == 21'd0) && !space_flag && !punct_flag && !cjk_flag && stream_end)
  `USDC_ASSERT_NOW(a_valid_scalar, clk, rst, out_valid && code_valid,
    (char_code < usdc_pkg::CP_LIMIT) &&
    ((char_code < usdc_pkg::SURR_LO) || (char_code > usdc_pkg::SURR_HI)))
  `USDC_ASSERT_NOW(a_class_exclusive, clk, rst, out_valid, !(punct_flag && cjk_flag))
  `USDC_ASSERT_NEXT(a_end_closes_seq, clk, rst, adv && inq_last, !dres.seq_open)

endmodule
